// File: design/vdbw_pkg.sv
// ----------------------------------------------------------------------------
// Volume distance blend weight package
// Shared constants, register codes and transaction payload types.
// ----------------------------------------------------------------------------
package vdbw_pkg;

	localparam int COORD_BITS = 20;
	localparam int FRAC_BITS_DEFAULT = 8;
	localparam int WEIGHT_FRAC = 16;
	localparam int BOX_SQ_W = 64;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [WEIGHT_FRAC:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC{1'b0}}};

	localparam logic [1:0] SHAPE_GLOBAL = 2'd0;
	localparam logic [1:0] SHAPE_SPHERE = 2'd1;

	localparam logic [1:0] REG_CAMERA_X = 2'd0;
	localparam logic [1:0] REG_CAMERA_Y = 2'd1;
	localparam logic [1:0] REG_CAMERA_Z = 2'd2;

	typedef struct packed {
		logic [COORD_BITS-2:0]   blend_distance;
		logic [3*COORD_BITS-1:0] box_dimensions;
		logic [COORD_BITS-2:0]   sphere_radius;
		logic [3*COORD_BITS-1:0] basis_col2;
		logic [3*COORD_BITS-1:0] basis_col1;
		logic [3*COORD_BITS-1:0] basis_col0;
		logic [3*COORD_BITS-1:0] scale_xyz;
		logic [3*COORD_BITS-1:0] position_xyz;
		logic [1:0]              volume_shape;
	} vdbw_vol_t;

	typedef struct packed {
		logic [COORD_BITS-2:0] distance;
		logic [WEIGHT_FRAC:0]  weight;
		logic                  contributes;
	} vdbw_res_t;

endpackage

// File: design/vdbw_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of several lanes, one result bit per stage, with a
// side payload and a valid bit that travel alongside.
// ----------------------------------------------------------------------------
module vdbw_isqrt #(
	parameter int IN_W = 42,
	parameter int LANES = 1,
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [IN_W-1:0]      rad [LANES],
	input  logic [SIDE_W-1:0]    side_in,
	output logic                 out_vld,
	output logic [IN_W/2-1:0]    root [LANES],
	output logic [SIDE_W-1:0]    side_out
);

	localparam int R = IN_W / 2;

	logic [R+1:0]      rem_q  [R][LANES];
	logic [R-1:0]      root_q [R][LANES];
	logic [IN_W-1:0]   bits_q [R][LANES];
	logic [SIDE_W-1:0] side_q [R];
	logic [R-1:0]      vld_q;

	for (genvar k = 0; k < R; k++) begin : g_stage
		logic [R+1:0]      rem_p  [LANES];
		logic [R-1:0]      root_p [LANES];
		logic [IN_W-1:0]   bits_p [LANES];
		logic [SIDE_W-1:0] side_p;
		logic              vld_p;
		logic [R+3:0]      cand   [LANES];
		logic [R+3:0]      trial  [LANES];
		logic [R+1:0]      rem_n  [LANES];
		logic [R-1:0]      root_n [LANES];
		logic [IN_W-1:0]   bits_n [LANES];

		if (k == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					rem_p[l] = '0;
					root_p[l] = '0;
					bits_p[l] = rad[l];
				end
			end
			assign side_p = side_in;
			assign vld_p = in_vld;
		end else begin : g_next
			assign rem_p = rem_q[k-1];
			assign root_p = root_q[k-1];
			assign bits_p = bits_q[k-1];
			assign side_p = side_q[k-1];
			assign vld_p = vld_q[k-1];
		end

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				cand[l] = {rem_p[l], bits_p[l][IN_W-1 -: 2]};
				trial[l] = {2'b00, root_p[l], 2'b01};
				bits_n[l] = {bits_p[l][IN_W-3:0], 2'b00};
				if (cand[l] >= trial[l]) begin
					rem_n[l] = (R+2)'(cand[l] - trial[l]);
					root_n[l] = {root_p[l][R-2:0], 1'b1};
				end else begin
					rem_n[l] = (R+2)'(cand[l]);
					root_n[l] = {root_p[l][R-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= rem_n;
				root_q[k] <= root_n;
				bits_q[k] <= bits_n;
				side_q[k] <= side_p;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_p;
			end
		end
	end

	assign root = root_q[R-1];
	assign side_out = side_q[R-1];
	assign out_vld = vld_q[R-1];

endmodule

// File: design/vdbw_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division of several lanes, one quotient bit per stage, with a
// side payload and a valid bit that travel alongside.
// ----------------------------------------------------------------------------
module vdbw_div #(
	parameter int NUM_W = 41,
	parameter int DEN_W = 21,
	parameter int LANES = 1,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  num [LANES],
	input  logic [DEN_W-1:0]  den [LANES],
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [NUM_W-1:0]  quo [LANES],
	output logic [SIDE_W-1:0] side_out
);

	logic [DEN_W-1:0]  rem_q  [NUM_W][LANES];
	logic [NUM_W-1:0]  num_q  [NUM_W][LANES];
	logic [DEN_W-1:0]  den_q  [NUM_W][LANES];
	logic [SIDE_W-1:0] side_q [NUM_W];
	logic [NUM_W-1:0]  vld_q;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W-1:0]  rem_p [LANES];
		logic [NUM_W-1:0]  num_p [LANES];
		logic [DEN_W-1:0]  den_p [LANES];
		logic [SIDE_W-1:0] side_p;
		logic              vld_p;
		logic [DEN_W:0]    cand  [LANES];
		logic [DEN_W-1:0]  rem_n [LANES];
		logic [NUM_W-1:0]  num_n [LANES];

		if (k == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					rem_p[l] = '0;
					num_p[l] = num[l];
					den_p[l] = den[l];
				end
			end
			assign side_p = side_in;
			assign vld_p = in_vld;
		end else begin : g_next
			assign rem_p = rem_q[k-1];
			assign num_p = num_q[k-1];
			assign den_p = den_q[k-1];
			assign side_p = side_q[k-1];
			assign vld_p = vld_q[k-1];
		end

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				cand[l] = {rem_p[l], num_p[l][NUM_W-1]};
				if (cand[l] >= {1'b0, den_p[l]}) begin
					rem_n[l] = DEN_W'(cand[l] - {1'b0, den_p[l]});
					num_n[l] = {num_p[l][NUM_W-2:0], 1'b1};
				end else begin
					rem_n[l] = DEN_W'(cand[l]);
					num_n[l] = {num_p[l][NUM_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= rem_n;
				num_q[k] <= num_n;
				den_q[k] <= den_p;
				side_q[k] <= side_p;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_p;
			end
		end
	end

	assign quo = num_q[NUM_W-1];
	assign side_out = side_q[NUM_W-1];
	assign out_vld = vld_q[NUM_W-1];

endmodule

// File: design/volume_distance_blend_weight_unit.sv
// ----------------------------------------------------------------------------
// Volume distance blend weight unit
// Distance from the camera to a global, sphere or oriented box volume, and
// the fade weight that follows from the blend distance.
// ----------------------------------------------------------------------------
// Usage:
// The camera position is written through the APB port at byte addresses 0, 4
// and 8 while no transaction is in flight. Each input transaction on the vol
// channel describes one volume and yields exactly one result transaction on
// the res channel, in order.
// The datapath is one pipeline: offsets and products, two square root units
// (one result bit per stage), a divider for the local box coordinates and a
// divider for the weight (one quotient bit per stage). A new transaction is
// accepted in every cycle in which the pipeline is not held; throughput is
// one per cycle. When the receiver holds res_ready low with a result waiting,
// the whole pipeline holds and vol_ready drops until the result is taken.
// Reset clears the camera registers and all pipeline valid bits.
// ----------------------------------------------------------------------------
module volume_distance_blend_weight_unit import vdbw_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  vol_valid,
	output logic                  vol_ready,
	input  vdbw_vol_t             vol,
	output logic                  res_valid,
	input  logic                  res_ready,
	output vdbw_res_t             res
);

	localparam int C = COORD_BITS;
	localparam int UW = C - 1;
	localparam int PW = 2 * C + 1;
	localparam int DSW = 2 * C + 3;
	localparam int DOT_W = 2 * C + 1;
	localparam int SQA_W = 2 * C + 2;
	localparam int RA_W = SQA_W / 2;
	localparam int HALF_W = 2 * C - FRAC_BITS - 1;
	localparam int SR_W = 2 * C - 1 - FRAC_BITS;
	localparam int CMP_W = (SR_W > RA_W) ? SR_W : RA_W;
	localparam int RB_W = BOX_SQ_W / 2;
	localparam int WN_W = UW + WEIGHT_FRAC;
	localparam int SIDE_A_W = 2 + 3 * DOT_W + 3 * HALF_W + SR_W + UW;
	localparam int SIDE_D_W = 2 + 3 * HALF_W + 3 + 2 * UW;
	localparam logic [UW-1:0] UMAX = '1;

	typedef struct packed {
		logic [1:0]    shape;
		logic [UW-1:0] dsph;
		logic [UW-1:0] blend;
	} carry_t;

	logic                 en;
	logic signed [C-1:0]  cam_q [3];

	// Input lane extraction.
	logic signed [C-1:0]  pos_c  [3];
	logic signed [C-1:0]  scl_c  [3];
	logic signed [C-1:0]  col_c  [3][3];
	logic signed [C:0]    off_c  [3];
	logic [C-1:0]         smag_c [3];
	logic [C-1:0]         cmag_c [3][3];
	logic [C-1:0]         omag_c [3];

	// Stage 1.
	logic                 vld_s1;
	logic [1:0]           shape_s1;
	logic signed [C:0]    off_s1  [3];
	logic signed [C-1:0]  col_s1  [3][3];
	logic [C-1:0]         cmag_s1 [3][3];
	logic [C-1:0]         omag_s1 [3];
	logic [C-1:0]         smag_s1 [3];
	logic [C-1:0]         dim_s1  [3];
	logic [UW-1:0]        radius_s1;
	logic [UW-1:0]        blend_s1;

	// Stage 2.
	logic                 vld_s2;
	logic [1:0]           shape_s2;
	logic signed [PW-1:0] prod_s2 [3][3];
	logic [2*C-1:0]       csq_s2  [3][3];
	logic [2*C-1:0]       osq_s2  [3];
	logic [2*C-1:0]       hraw_s2 [3];
	logic [C-1:0]         smax_c;
	logic [C-1:0]         smax_s2;
	logic [UW-1:0]        radius_s2;
	logic [UW-1:0]        blend_s2;

	// Stage 3.
	logic                  vld_s3;
	logic [1:0]            shape_s3;
	logic signed [DSW-1:0] dots_s3 [3];
	logic [SQA_W-1:0]      nsq_s3  [3];
	logic [SQA_W-1:0]      lsq_s3;
	logic [HALF_W-1:0]     half_s3 [3];
	logic [2*C-2:0]        srraw_s3;
	logic [UW-1:0]         blend_s3;

	// Stage 4.
	logic                  vld_s4;
	logic [1:0]            shape_s4;
	logic [DOT_W-1:0]      adot_s4 [3];
	logic [SQA_W-1:0]      nsq_s4  [3];
	logic [SQA_W-1:0]      lsq_s4;
	logic [HALF_W-1:0]     half_s4 [3];
	logic [SR_W-1:0]       sr_s4;
	logic [UW-1:0]         blend_s4;

	// First square root unit.
	logic [SQA_W-1:0]      rad_a  [4];
	logic [RA_W-1:0]       root_a [4];
	logic [SIDE_A_W-1:0]   side_a_in;
	logic [SIDE_A_W-1:0]   side_a_out;
	logic                  vld_a;
	logic [1:0]            shape_a;
	logic [DOT_W-1:0]      adot_a [3];
	logic [HALF_W-1:0]     half_a [3];
	logic [SR_W-1:0]       sr_a;
	logic [UW-1:0]         blend_a;
	logic [CMP_W-1:0]      lx_c;
	logic [CMP_W-1:0]      sx_c;
	logic [CMP_W-1:0]      diff_c;
	logic [UW-1:0]         dsph_c;

	// Stage 5.
	logic                  vld_s5;
	logic [1:0]            shape_s5;
	logic [DOT_W-1:0]      adot_s5 [3];
	logic [RA_W-1:0]       n_s5    [3];
	logic [2:0]            nz_s5;
	logic [HALF_W-1:0]     half_s5 [3];
	logic [UW-1:0]         dsph_s5;
	logic [UW-1:0]         blend_s5;

	// Box coordinate divider.
	logic [SIDE_D_W-1:0]   side_d_in;
	logic [SIDE_D_W-1:0]   side_d_out;
	logic [DOT_W-1:0]      loc_d  [3];
	logic                  vld_d;
	logic [1:0]            shape_d;
	logic [HALF_W-1:0]     half_d [3];
	logic [2:0]            nz_d;
	logic [UW-1:0]         dsph_d;
	logic [UW-1:0]         blend_d;

	// Stages 6 to 9.
	logic                  vld_s6;
	logic                  vld_s7;
	logic                  vld_s8;
	logic                  vld_s9;
	carry_t                carry_s6;
	carry_t                carry_s7;
	carry_t                carry_s8;
	carry_t                carry_s9;
	logic [DOT_W-1:0]      outv_s6 [3];
	logic [BOX_SQ_W-1:0]   a64_c   [3];
	logic [31:0]           p1_c    [3];
	logic [BOX_SQ_W-1:0]   p0_s7   [3];
	logic [31:0]           p1_s7   [3];
	logic [BOX_SQ_W-1:0]   sq_s8   [3];
	logic [BOX_SQ_W-1:0]   sum_s9;

	// Box length square root unit.
	logic [BOX_SQ_W-1:0]   rad_b  [1];
	logic [RB_W-1:0]       root_b [1];
	logic                  vld_b;
	carry_t                carry_b;
	logic [UW-1:0]         d_c;

	// Stage 10.
	logic                  vld_s10;
	logic [UW-1:0]         d_s10;
	logic                  bz_s10;

	// Weight divider.
	logic [WN_W-1:0]       num_w [1];
	logic [UW-1:0]         den_w [1];
	logic [WN_W-1:0]       quo_w [1];
	logic                  vld_w;
	logic [UW-1:0]         d_w;
	logic                  bz_w;
	logic [WEIGHT_FRAC:0]  w_c;

	// Stage 11, the output register.
	logic                  vld_s11;
	vdbw_res_t             res_s11;

	assign en = !vld_s11 || res_ready;
	assign vol_ready = en;
	assign res_valid = vld_s11;
	assign res = res_s11;
	assign pready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q[0] <= '0;
			cam_q[1] <= '0;
			cam_q[2] <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[APB_ADDR_W-1:2])
				REG_CAMERA_X: cam_q[0] <= pwdata[C-1:0];
				REG_CAMERA_Y: cam_q[1] <= pwdata[C-1:0];
				REG_CAMERA_Z: cam_q[2] <= pwdata[C-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[APB_ADDR_W-1:2])
			REG_CAMERA_X: prdata = APB_DATA_W'(cam_q[0]);
			REG_CAMERA_Y: prdata = APB_DATA_W'(cam_q[1]);
			REG_CAMERA_Z: prdata = APB_DATA_W'(cam_q[2]);
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pos_c[k] = $signed(vol.position_xyz[k*C +: C]);
			scl_c[k] = $signed(vol.scale_xyz[k*C +: C]);
			col_c[0][k] = $signed(vol.basis_col0[k*C +: C]);
			col_c[1][k] = $signed(vol.basis_col1[k*C +: C]);
			col_c[2][k] = $signed(vol.basis_col2[k*C +: C]);
			off_c[k] = (C+1)'(cam_q[k]) - (C+1)'(pos_c[k]);
			smag_c[k] = scl_c[k][C-1] ? C'(-scl_c[k]) : C'(scl_c[k]);
			omag_c[k] = off_c[k][C] ? C'(-off_c[k]) : C'(off_c[k]);
		end
		for (int a = 0; a < 3; a++) begin
			for (int k = 0; k < 3; k++) begin
				cmag_c[a][k] = col_c[a][k][C-1] ? C'(-col_c[a][k]) : C'(col_c[a][k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			shape_s1 <= vol.volume_shape;
			radius_s1 <= vol.sphere_radius;
			blend_s1 <= vol.blend_distance;
			for (int k = 0; k < 3; k++) begin
				off_s1[k] <= off_c[k];
				omag_s1[k] <= omag_c[k];
				smag_s1[k] <= smag_c[k];
				dim_s1[k] <= vol.box_dimensions[k*C +: C];
			end
			col_s1 <= col_c;
			cmag_s1 <= cmag_c;
		end
	end

	always_comb begin
		smax_c = smag_s1[0];
		if (smag_s1[1] > smax_c) begin
			smax_c = smag_s1[1];
		end
		if (smag_s1[2] > smax_c) begin
			smax_c = smag_s1[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			shape_s2 <= shape_s1;
			radius_s2 <= radius_s1;
			blend_s2 <= blend_s1;
			smax_s2 <= smax_c;
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s2[a][k] <= PW'(col_s1[a][k]) * PW'(off_s1[k]);
					csq_s2[a][k] <= (2*C)'(cmag_s1[a][k]) * (2*C)'(cmag_s1[a][k]);
				end
			end
			for (int k = 0; k < 3; k++) begin
				osq_s2[k] <= (2*C)'(omag_s1[k]) * (2*C)'(omag_s1[k]);
				hraw_s2[k] <= (2*C)'(dim_s1[k]) * (2*C)'(smag_s1[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			shape_s3 <= shape_s2;
			blend_s3 <= blend_s2;
			srraw_s3 <= (2*C-1)'(radius_s2) * (2*C-1)'(smax_s2);
			lsq_s3 <= SQA_W'(osq_s2[0]) + SQA_W'(osq_s2[1]) + SQA_W'(osq_s2[2]);
			for (int a = 0; a < 3; a++) begin
				dots_s3[a] <= DSW'(prod_s2[a][0]) + DSW'(prod_s2[a][1]) + DSW'(prod_s2[a][2]);
				nsq_s3[a] <= SQA_W'(csq_s2[a][0]) + SQA_W'(csq_s2[a][1])
					+ SQA_W'(csq_s2[a][2]);
				half_s3[a] <= HALF_W'(hraw_s2[a] >> (FRAC_BITS + 1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			shape_s4 <= shape_s3;
			blend_s4 <= blend_s3;
			lsq_s4 <= lsq_s3;
			sr_s4 <= SR_W'(srraw_s3 >> FRAC_BITS);
			nsq_s4 <= nsq_s3;
			half_s4 <= half_s3;
			for (int a = 0; a < 3; a++) begin
				adot_s4[a] <= dots_s3[a][DSW-1] ? DOT_W'(-dots_s3[a]) : DOT_W'(dots_s3[a]);
			end
		end
	end

	assign rad_a[0] = nsq_s4[0];
	assign rad_a[1] = nsq_s4[1];
	assign rad_a[2] = nsq_s4[2];
	assign rad_a[3] = lsq_s4;
	assign side_a_in = {shape_s4, adot_s4[0], adot_s4[1], adot_s4[2],
		half_s4[0], half_s4[1], half_s4[2], sr_s4, blend_s4};

	vdbw_isqrt #(
		.IN_W(SQA_W),
		.LANES(4),
		.SIDE_W(SIDE_A_W)
	) u_isqrt_len (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s4),
		.rad(rad_a),
		.side_in(side_a_in),
		.out_vld(vld_a),
		.root(root_a),
		.side_out(side_a_out)
	);

	assign {shape_a, adot_a[0], adot_a[1], adot_a[2],
		half_a[0], half_a[1], half_a[2], sr_a, blend_a} = side_a_out;

	always_comb begin
		lx_c = CMP_W'(root_a[3]);
		sx_c = CMP_W'(sr_a);
		diff_c = (lx_c > sx_c) ? lx_c - sx_c : '0;
		dsph_c = (diff_c > CMP_W'(UMAX)) ? UMAX : UW'(diff_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			shape_s5 <= shape_a;
			blend_s5 <= blend_a;
			dsph_s5 <= dsph_c;
			adot_s5 <= adot_a;
			half_s5 <= half_a;
			for (int a = 0; a < 3; a++) begin
				n_s5[a] <= root_a[a];
				nz_s5[a] <= root_a[a] != '0;
			end
		end
	end

	assign side_d_in = {shape_s5, half_s5[0], half_s5[1], half_s5[2], nz_s5, dsph_s5, blend_s5};

	vdbw_div #(
		.NUM_W(DOT_W),
		.DEN_W(RA_W),
		.LANES(3),
		.SIDE_W(SIDE_D_W)
	) u_div_local (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s5),
		.num(adot_s5),
		.den(n_s5),
		.side_in(side_d_in),
		.out_vld(vld_d),
		.quo(loc_d),
		.side_out(side_d_out)
	);

	assign {shape_d, half_d[0], half_d[1], half_d[2], nz_d, dsph_d, blend_d} = side_d_out;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			a64_c[a] = BOX_SQ_W'(outv_s6[a]);
			p1_c[a] = a64_c[a][63:32] * a64_c[a][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s6 <= '{shape: shape_d, dsph: dsph_d, blend: blend_d};
			for (int a = 0; a < 3; a++) begin
				if (nz_d[a] && loc_d[a] > DOT_W'(half_d[a])) begin
					outv_s6[a] <= loc_d[a] - DOT_W'(half_d[a]);
				end else begin
					outv_s6[a] <= '0;
				end
			end
			carry_s7 <= carry_s6;
			for (int a = 0; a < 3; a++) begin
				p0_s7[a] <= BOX_SQ_W'(a64_c[a][31:0]) * BOX_SQ_W'(a64_c[a][31:0]);
				p1_s7[a] <= p1_c[a];
			end
			carry_s8 <= carry_s7;
			for (int a = 0; a < 3; a++) begin
				sq_s8[a] <= p0_s7[a] + {p1_s7[a][30:0], 33'b0};
			end
			carry_s9 <= carry_s8;
			sum_s9 <= sq_s8[0] + sq_s8[1] + sq_s8[2];
		end
	end

	assign rad_b[0] = sum_s9;

	vdbw_isqrt #(
		.IN_W(BOX_SQ_W),
		.LANES(1),
		.SIDE_W($bits(carry_t))
	) u_isqrt_box (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s9),
		.rad(rad_b),
		.side_in(carry_s9),
		.out_vld(vld_b),
		.root(root_b),
		.side_out(carry_b)
	);

	always_comb begin
		unique case (carry_b.shape)
			SHAPE_GLOBAL: d_c = '0;
			SHAPE_SPHERE: d_c = carry_b.dsph;
			default:      d_c = (root_b[0] > RB_W'(UMAX)) ? UMAX : UW'(root_b[0]);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s10 <= d_c;
			bz_s10 <= carry_b.blend == '0;
			den_w[0] <= carry_b.blend;
		end
	end

	assign num_w[0] = {d_s10, {WEIGHT_FRAC{1'b0}}};

	vdbw_div #(
		.NUM_W(WN_W),
		.DEN_W(UW),
		.LANES(1),
		.SIDE_W(UW + 1)
	) u_div_weight (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s10),
		.num(num_w),
		.den(den_w),
		.side_in({d_s10, bz_s10}),
		.out_vld(vld_w),
		.quo(quo_w),
		.side_out({d_w, bz_w})
	);

	always_comb begin
		if (bz_w) begin
			w_c = (d_w == '0) ? WEIGHT_ONE : '0;
		end else if (quo_w[0][WN_W-1:WEIGHT_FRAC] != '0) begin
			w_c = '0;
		end else begin
			w_c = WEIGHT_ONE - (WEIGHT_FRAC+1)'(quo_w[0][WEIGHT_FRAC-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s11.distance <= d_w;
			res_s11.weight <= w_c;
			res_s11.contributes <= w_c != '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vol_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_a;
			vld_s6 <= vld_d;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_b;
			vld_s11 <= vld_w;
		end
	end

endmodule

// File: sim/tb_volume_distance_blend_weight_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume distance blend weight unit testbench
// Drives volume transactions through a valid/ready driver, predicts distance
// and weight in fixed point, and compares each result transaction in order.
// The camera is rewritten over APB between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_volume_distance_blend_weight_unit;
	import vdbw_pkg::*;

	localparam int FB = FRAC_BITS_DEFAULT;
	localparam int CB = COORD_BITS;
	localparam int LATENCY = 4 * CB + 60;
	localparam logic [1:0] SHAPE_BOX = 2'd2;
	localparam logic [1:0] SHAPE_ALT_BOX = 2'd3;
	localparam longint DIST_MAX = (64'd1 << (CB - 1)) - 1;
	localparam int STALL_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic vol_valid = 1'b0;
	logic vol_ready;
	vdbw_vol_t vol = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	vdbw_res_t res;

	volume_distance_blend_weight_unit u_top (.*);

	always #5 clk = ~clk;

	longint cam [3];
	vdbw_vol_t pending_vols [$];
	vdbw_res_t expected_res [$];
	int errors = 0;
	int n_sent = 0, n_checked = 0;
	bit stall_start = 1'b0;
	bit stall_on = 1'b0;
	int send_gap = 0, recv_gap = 0;
	bit apb_busy = 1'b0;

	function automatic longint sx(logic [CB-1:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint len3(longint a, longint b, longint c);
		return isqrt(longint'(a * a + b * b + c * c));
	endfunction

	function automatic vdbw_res_t predict_blend(vdbw_vol_t v);
		vdbw_res_t r;
		longint off [3];
		longint d, smax, sr, l, n, dp, loc, half, w, q;
		longint outv [3];
		longint c [3];
		logic [3*CB-1:0] col;
		d = 0;
		if (v.volume_shape != SHAPE_GLOBAL) begin
			for (int k = 0; k < 3; k++)
				off[k] = cam[k] - sx(v.position_xyz[k*CB +: CB]);
			if (v.volume_shape == SHAPE_SPHERE) begin
				smax = 0;
				for (int k = 0; k < 3; k++)
					if (mag(sx(v.scale_xyz[k*CB +: CB])) > smax)
						smax = mag(sx(v.scale_xyz[k*CB +: CB]));
				sr = (longint'(v.sphere_radius) * smax) >>> FB;
				l = len3(mag(off[0]), mag(off[1]), mag(off[2]));
				d = l > sr ? l - sr : 0;
			end else begin
				for (int k = 0; k < 3; k++) begin
					col = k == 0 ? v.basis_col0 : (k == 1 ? v.basis_col1 : v.basis_col2);
					for (int j = 0; j < 3; j++) c[j] = sx(col[j*CB +: CB]);
					n = len3(mag(c[0]), mag(c[1]), mag(c[2]));
					dp = c[0] * off[0] + c[1] * off[1] + c[2] * off[2];
					loc = n != 0 ? mag(dp) / n : 0;
					half = (longint'(v.box_dimensions[k*CB +: CB])
						* mag(sx(v.scale_xyz[k*CB +: CB]))) >>> (FB + 1);
					outv[k] = loc > half ? loc - half : 0;
				end
				d = len3(outv[0], outv[1], outv[2]);
			end
			if (d > DIST_MAX) d = DIST_MAX;
		end
		if (v.blend_distance == 0) begin
			w = d == 0 ? 65536 : 0;
		end else begin
			q = (d * 65536) / longint'(v.blend_distance);
			w = q >= 65536 ? 0 : 65536 - q;
		end
		r.distance = d[CB-2:0];
		r.weight = w[16:0];
		r.contributes = w != 0;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH result %0d %s: got %0d expected %0d", n_checked, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (vol_valid && vol_ready) begin
			expected_res = {expected_res, predict_blend(vol)};
			n_sent++;
		end
		if (!vol_valid || vol_ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				vol_valid <= 1'b0;
			end else if (pending_vols.size() > 0 && arst_n && !apb_busy) begin
				vol <= pending_vols.pop_front();
				vol_valid <= 1'b1;
				send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
			end else begin
				vol_valid <= 1'b0;
			end
		end
	end

	initial begin
		wait (stall_start);
		stall_on <= 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		stall_on <= 1'b0;
	end

	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			if (expected_res.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				vdbw_res_t e;
				e = expected_res.pop_front();
				if (res.distance !== e.distance) report_mismatch("distance", res.distance, e.distance);
				if (res.weight !== e.weight) report_mismatch("weight", res.weight, e.weight);
				if (res.contributes !== e.contributes)
					report_mismatch("contributes", res.contributes, e.contributes);
			end
			n_checked++;
		end
		if (stall_on) begin
			res_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
			if (res_valid && res_ready)
				recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
		end
	end

	task automatic write_camera(logic [1:0] idx, longint value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(4 * idx); pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		cam[idx] = sx(value[CB-1:0]);
	endtask

	task automatic drain();
		while (pending_vols.size() > 0 || vol_valid || expected_res.size() > 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [3*CB-1:0] rand_lanes(int lim);
		logic [3*CB-1:0] p;
		for (int k = 0; k < 3; k++)
			p[k*CB +: CB] = CB'($urandom_range(0, 2 * lim) - lim);
		return p;
	endfunction

	function automatic logic [3*CB-1:0] wide_lanes();
		logic [3*CB-1:0] p;
		p = (3*CB)'({$urandom(), $urandom()});
		return p;
	endfunction

	function automatic vdbw_vol_t rand_vol(bit wild);
		vdbw_vol_t v;
		int lim;
		lim = wild ? 524287 : 8192;
		v.volume_shape = 2'($urandom_range(0, 3));
		v.position_xyz = wild ? wide_lanes() : rand_lanes(lim);
		v.scale_xyz = wild ? wide_lanes() : rand_lanes(1024);
		v.basis_col0 = wild ? wide_lanes() : rand_lanes(512);
		v.basis_col1 = wild ? wide_lanes() : rand_lanes(512);
		v.basis_col2 = wild ? wide_lanes() : rand_lanes(512);
		v.sphere_radius = wild ? 19'($urandom()) : 19'($urandom_range(0, 4096));
		v.box_dimensions = wild ? wide_lanes() : {3{20'($urandom_range(0, 4096))}};
		if (!wild) v.box_dimensions = {20'($urandom_range(0, 4096)),
			20'($urandom_range(0, 4096)), 20'($urandom_range(0, 4096))};
		v.blend_distance = ($urandom_range(0, 7) == 0) ? 19'd0 :
			(wild ? 19'($urandom()) : 19'($urandom_range(1, 8192)));
		return v;
	endfunction

	initial begin
		vdbw_vol_t v;
		longint cams [4][3];
		for (int k = 0; k < 3; k++) cam[k] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items with the camera at reset.
		v = '0;
		pending_vols = {pending_vols, v};
		v.volume_shape = SHAPE_SPHERE;
		pending_vols = {pending_vols, v};
		v.blend_distance = '1;
		pending_vols = {pending_vols, v};
		v.position_xyz = {20'h80000, 20'h80000, 20'h80000};
		v.scale_xyz = {20'h80000, 20'h7ffff, 20'h00100};
		v.sphere_radius = '1;
		pending_vols = {pending_vols, v};
		v.sphere_radius = '0;
		v.blend_distance = '0;
		pending_vols = {pending_vols, v};
		v.volume_shape = SHAPE_BOX;
		v.basis_col0 = '0; v.basis_col1 = '0; v.basis_col2 = '0;
		pending_vols = {pending_vols, v};
		v.basis_col0 = {20'd0, 20'd0, 20'h00100};
		v.basis_col1 = {20'd0, 20'h00100, 20'd0};
		v.basis_col2 = {20'h00100, 20'd0, 20'd0};
		v.box_dimensions = '1;
		pending_vols = {pending_vols, v};
		v.box_dimensions = '0;
		v.blend_distance = 19'h100;
		pending_vols = {pending_vols, v};
		v.volume_shape = SHAPE_ALT_BOX;
		v.basis_col0 = '1; v.basis_col1 = {3{20'h80000}}; v.basis_col2 = {3{20'h7ffff}};
		pending_vols = {pending_vols, v};
		v.position_xyz = {3{20'h7ffff}};
		v.scale_xyz = '1;
		v.box_dimensions = {3{20'h7ffff}};
		pending_vols = {pending_vols, v};
		for (int i = 0; i < 6; i++) pending_vols = {pending_vols, rand_vol(1'b1)};
		drain();

		cams[0] = '{524287, -524288, 0};
		cams[1] = '{-524288, 524287, -1};
		cams[2] = '{1024, -2048, 300};
		cams[3] = '{0, 0, 0};
		for (int ph = 0; ph < 4; ph++) begin
			apb_busy = 1'b1;
			for (int k = 0; k < 3; k++) begin
				longint c;
				c = (ph == 2) ? longint'($urandom_range(0, 16384)) - 8192 : cams[ph][k];
				write_camera(2'(k), c);
			end
			apb_busy = 1'b0;
			if (ph == 1) begin
				for (int i = 0; i < 60; i++) pending_vols = {pending_vols, rand_vol(1'b0)};
				stall_start = 1'b1;
			end
			for (int i = 0; i < 80; i++)
				pending_vols = {pending_vols, rand_vol($urandom_range(0, 4) == 0)};
			drain();
		end

		$display("Sent %0d and checked %0d volume transactions over directed extremes and four cameras.",
			n_sent, n_checked);
		$display("Included zero bases, hard edges, shape three and a long receiver stall.");
		if (errors == 0 && expected_res.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
